@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that an implication holds at every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// check that a condition holds in the cycle after another
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`endif

@@ sv/msff_pkg.sv @@
// Package with types, constants and default table for the speed feedforward block
package msff_pkg;
  localparam int DefPoints = 11;
  localparam int TablePointsDef = 11;

  localparam logic [1:0] CMD_STEP  = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [2:0] REG_RPM_MAX   = 3'd0;
  localparam logic [2:0] REG_PWM_MAX   = 3'd1;
  localparam logic [2:0] REG_KNEE      = 3'd2;
  localparam logic [2:0] REG_STEP_UP   = 3'd3;
  localparam logic [2:0] REG_STEP_DOWN = 3'd4;
  localparam logic [2:0] REG_KI        = 3'd5;
  localparam logic [2:0] REG_DEADBAND  = 3'd6;
  localparam logic [2:0] REG_HOLD      = 3'd7;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] target_rpm;
    logic [11:0] measured_rpm;
    logic [3:0]  entry_index;
    logic [11:0] entry_rpm;
    logic [11:0] entry_pwm;
  } msff_in_t;

  typedef struct packed {
    logic [11:0] pwm_out;
    logic [11:0] ramped_target;
    logic        target_stable;
    logic        calibrating;
    logic        point_saved;
    logic [3:0]  saved_index;
    logic [11:0] saved_pwm;
    logic        calibration_done;
  } msff_out_t;

  typedef struct packed {
    logic [11:0] rpm_max;
    logic [11:0] pwm_max;
    logic [11:0] ramp_knee;
    logic [3:0]  step_up;
    logic [3:0]  step_down;
    logic [15:0] ki_q16;
    logic [7:0]  error_deadband;
    logic [11:0] cal_hold_steps;
  } msff_cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic start;      // latch input; step the ramp, load an entry or start calibration
    logic seg_load;   // read segment at seg index
    logic seg_test;   // test enclosure of loaded segment
    logic mul;        // multiply stage
    logic div_start;  // start divider
    logic finish;     // commit and form result
  } msff_cmd_t;

  typedef struct packed {
    logic seg_hit;
    logic seg_last;
    logic div_busy;
  } msff_stat_t;

  function automatic logic [11:0] def_speed(input int i);
    logic [11:0] v;
    unique case (i)
      0: v = 12'd0;    1: v = 12'd60;   2: v = 12'd100;  3: v = 12'd200;
      4: v = 12'd400;  5: v = 12'd700;  6: v = 12'd1000; 7: v = 12'd1300;
      8: v = 12'd1600; 9: v = 12'd1900; default: v = 12'd2130;
    endcase
    return v;
  endfunction

  function automatic logic [11:0] def_drive(input int i);
    logic [11:0] v;
    unique case (i)
      0: v = 12'd0;    1: v = 12'd175;  2: v = 12'd210;  3: v = 12'd303;
      4: v = 12'd504;  5: v = 12'd829;  6: v = 12'd1168; 7: v = 12'd1513;
      8: v = 12'd1865; 9: v = 12'd2217; default: v = 12'd2481;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] def_tol(input int i);
    logic [4:0] v;
    unique case (i)
      0: v = 5'd10; 1: v = 5'd5;  2: v = 5'd5;  3: v = 5'd10; 4: v = 5'd10;
      5: v = 5'd15; 6: v = 5'd15; 7: v = 5'd20; 8: v = 5'd20; 9: v = 5'd25;
      default: v = 5'd25;
    endcase
    return v;
  endfunction
endpackage

@@ sv/motor_speed_feedforward_with_selfcal.sv @@
// One transaction at a time: the next input is taken in the cycle after the result leaves.
// Synchronous active-low reset restores the default configuration and table.
// Top level of the speed feedforward block with self-calibration
`include "assert_macros.svh"
module motor_speed_feedforward_with_selfcal import msff_pkg::*; #(
  parameter int TablePoints = TablePointsDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  msff_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output msff_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  msff_cfg_t  cfg_r;
  msff_cmd_t  cmd;
  msff_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{rpm_max: 12'd2130, pwm_max: 12'd4000, ramp_knee: 12'd186,
                 step_up: 4'd2, step_down: 4'd4, ki_q16: 16'd328,
                 error_deadband: 8'd3, cal_hold_steps: 12'd300};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RPM_MAX:   cfg_r.rpm_max <= cfg_data[11:0];
        REG_PWM_MAX:   cfg_r.pwm_max <= cfg_data[11:0];
        REG_KNEE:      cfg_r.ramp_knee <= cfg_data[11:0];
        REG_STEP_UP:   cfg_r.step_up <= cfg_data[3:0];
        REG_STEP_DOWN: cfg_r.step_down <= cfg_data[3:0];
        REG_KI:        cfg_r.ki_q16 <= cfg_data;
        REG_DEADBAND:  cfg_r.error_deadband <= cfg_data[7:0];
        REG_HOLD:      cfg_r.cal_hold_steps <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  msff_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_cmd(in_data.cmd),
    .cal_mode(out_data.calibrating), .in_ready(in_ready), .out_valid(out_valid),
    .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  msff_datapath #(.TablePoints(TablePoints)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .item(in_data), .cmd(cmd),
    .stat(stat), .result(out_data)
  );

  `ASSERT_IMPL(a_no_accept_busy, in_valid && in_ready, !out_valid)
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_IMPL(a_saved_zero, out_valid && !out_data.point_saved, out_data.saved_pwm == 12'd0)
endmodule

@@ sv/msff_div.sv @@
// Restoring divider, one quotient bit per cycle
module msff_div import msff_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] num,
  input  logic [11:0] den,
  output logic        busy,
  output logic [11:0] quo
);
  logic [4:0]  cnt_r;
  logic [23:0] q_r;
  logic [12:0] rem_r;
  logic [12:0] trial;
  logic        busy_r;

  assign trial = {rem_r[11:0], q_r[23]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'd24;
      q_r    <= num;
      rem_r  <= '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_r <= trial - {1'b0, den};
        q_r   <= {q_r[22:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[22:0], 1'b0};
      end
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  // quotient stays below 4096 since the target lies inside the segment
  assign quo  = q_r[11:0];
endmodule

@@ sv/msff_datapath.sv @@
// Datapath: ramp, table, segment search, interpolation and integral controller
module msff_datapath import msff_pkg::*; #(
  parameter int TablePoints = TablePointsDef,
  localparam int IdxW = $clog2(TablePoints)
) (
  input  logic      clk,
  input  logic      rst_n,
  input  msff_cfg_t cfg,
  input  msff_in_t  item,
  input  msff_cmd_t cmd,
  output msff_stat_t stat,
  output msff_out_t result
);
  logic [11:0] tspd_r [TablePoints];
  logic [11:0] tdrv_r [TablePoints];
  logic [4:0]  ttol_r [TablePoints];

  msff_in_t    in_r;
  logic [11:0] ramp_r, last_r;
  logic        stable_r, cal_r, saved_r, done_r;
  logic [IdxW-1:0] point_r, sidx_r, seg_r;
  logic [11:0] hold_r, spwm_r;
  logic [27:0] integ_r;
  logic [11:0] s0_r, s1_r, d0_r, d1_r;
  logic [23:0] num_r;
  logic [11:0] ds_r, drive_r;
  logic        hit_r;
  logic        end_r;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TablePoints - 1);

  // ramp logic
  logic [11:0] want, clamp_t, stp, ramp_nxt;
  logic        stable_nxt;
  always_comb begin
    want = cal_r ? tspd_r[point_r] : item.target_rpm;
    clamp_t = (want > cfg.rpm_max) ? cfg.rpm_max : want;
    ramp_nxt = ramp_r;
    stable_nxt = 1'b0;
    if (clamp_t > ramp_r) begin
      stp = (ramp_r < cfg.ramp_knee) ? 12'd1 : {8'd0, cfg.step_up};
      ramp_nxt = (clamp_t - ramp_r > stp) ? ramp_r + stp : clamp_t;
    end else if (clamp_t < ramp_r) begin
      stp = (ramp_r < cfg.ramp_knee) ? 12'd1 : {8'd0, cfg.step_down};
      ramp_nxt = (ramp_r - clamp_t > stp) ? ramp_r - stp : clamp_t;
    end else begin
      stp = 12'd0;
      stable_nxt = 1'b1;
    end
  end

  // integral term
  logic signed [13:0] err;
  logic [12:0]        mag;
  logic signed [30:0] prod;
  logic signed [31:0] acc;
  logic [27:0]        top, integ_nxt;
  always_comb begin
    err  = $signed({2'b0, ramp_r}) - $signed({2'b0, in_r.measured_rpm});
    mag  = err[13] ? 13'(-err) : 13'(err);
    prod = $signed({1'b0, cfg.ki_q16}) * err;
    acc  = $signed({4'b0, integ_r});
    if (mag > {5'd0, cfg.error_deadband}) acc = acc + 32'(prod);
    top = {cfg.pwm_max, 16'd0};
    if (acc < 0) integ_nxt = '0;
    else if (acc > $signed({4'b0, top})) integ_nxt = top;
    else integ_nxt = acc[27:0];
  end

  logic        div_busy;
  logic [11:0] quo;
  msff_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(num_r), .den(ds_r),
    .busy(div_busy), .quo(quo)
  );

  logic [11:0] diff_m;
  logic [11:0] drv_fin;
  always_comb begin
    diff_m = (in_r.measured_rpm > tspd_r[point_r]) ? in_r.measured_rpm - tspd_r[point_r]
                                                   : tspd_r[point_r] - in_r.measured_rpm;
    if (cal_r) drv_fin = integ_nxt[27:16];
    else if (!hit_r) drv_fin = 12'd0;
    else if (ds_r == 12'd0) drv_fin = d0_r;
    else drv_fin = quo;
    if (drv_fin > cfg.pwm_max) drv_fin = cfg.pwm_max;
  end

  logic signed [24:0] mulnum;
  always_comb begin
    mulnum = $signed({13'd0, d0_r}) * $signed({1'b0, ds_r})
           + ($signed({1'b0, d1_r}) - $signed({1'b0, d0_r}))
           * $signed({1'b0, ramp_r - s0_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r <= '0; stable_r <= 1'b0; integ_r <= '0; last_r <= '0;
      cal_r <= 1'b0; point_r <= LastIdx; hold_r <= '0;
      saved_r <= 1'b0; done_r <= 1'b0; sidx_r <= '0; spwm_r <= '0;
      for (int i = 0; i < TablePoints; i++) begin
        tspd_r[i] <= def_speed(i < DefPoints ? i : DefPoints - 1);
        tdrv_r[i] <= def_drive(i < DefPoints ? i : DefPoints - 1);
        ttol_r[i] <= def_tol(i < DefPoints ? i : DefPoints - 1);
      end
    end else begin
      if (cmd.start) begin
        in_r <= item;
        saved_r <= 1'b0; done_r <= 1'b0; sidx_r <= '0; spwm_r <= '0;
        seg_r <= IdxW'(1);
        hit_r <= 1'b0;
        end_r <= 1'b0;
        unique case (item.cmd)
          CMD_STEP: begin
            ramp_r <= ramp_nxt;
            stable_r <= stable_nxt;
          end
          CMD_LOAD: begin
            if ({2'b0, item.entry_index} < 6'(TablePoints)) begin
              tspd_r[IdxW'(item.entry_index)] <= item.entry_rpm;
              tdrv_r[IdxW'(item.entry_index)] <= item.entry_pwm;
            end
          end
          CMD_START: begin
            cal_r <= 1'b1; point_r <= LastIdx; hold_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.seg_load) begin
        s0_r <= tspd_r[seg_r - IdxW'(1)]; s1_r <= tspd_r[seg_r];
        d0_r <= tdrv_r[seg_r - IdxW'(1)]; d1_r <= tdrv_r[seg_r];
      end
      if (cmd.seg_test) begin
        if (ramp_r >= s0_r && ramp_r <= s1_r) begin
          hit_r <= 1'b1;
          ds_r <= s1_r - s0_r;
        end else if (seg_r == LastIdx) end_r <= 1'b1;
        else seg_r <= seg_r + IdxW'(1);
      end
      if (cmd.mul) num_r <= mulnum[24] ? 24'd0 : mulnum[23:0];
      if (cmd.finish) begin
        if (cal_r) begin
          integ_r <= integ_nxt;
          if ({7'd0, diff_m} <= {14'd0, ttol_r[point_r]}) begin
            if (hold_r >= cfg.cal_hold_steps) begin
              tdrv_r[point_r] <= last_r;
              saved_r <= 1'b1; sidx_r <= point_r; spwm_r <= last_r;
              if (point_r > IdxW'(1)) point_r <= point_r - IdxW'(1);
              else begin
                cal_r <= 1'b0; point_r <= LastIdx; done_r <= 1'b1;
              end
              hold_r <= (12'd0 < cfg.cal_hold_steps) ? 12'd1 : 12'd0;
            end else hold_r <= (hold_r < cfg.cal_hold_steps) ? hold_r + 12'd1 : hold_r;
          end else hold_r <= (12'd0 < cfg.cal_hold_steps) ? 12'd1 : 12'd0;
        end else begin
          hold_r <= (hold_r < cfg.cal_hold_steps) ? hold_r + 12'd1 : hold_r;
        end
        last_r <= drv_fin;
      end
    end
  end

  assign stat.seg_hit  = hit_r;
  assign stat.seg_last = end_r;
  assign stat.div_busy = div_busy;

  assign result.pwm_out          = last_r;
  assign result.ramped_target    = ramp_r;
  assign result.target_stable    = stable_r;
  assign result.calibrating      = cal_r;
  assign result.point_saved      = saved_r;
  assign result.saved_index      = 4'(sidx_r);
  assign result.saved_pwm        = spwm_r;
  assign result.calibration_done = done_r;
endmodule

@@ sv/msff_ctrl.sv @@
// Controller state machine sequencing one transaction through the datapath
module msff_ctrl import msff_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_cmd,
  input  logic       cal_mode,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  msff_stat_t stat,
  output msff_cmd_t  cmd
);
  typedef enum logic [3:0] {S_IDLE, S_LOAD, S_TEST, S_CHK, S_MUL, S_DIV, S_WAIT, S_FIN,
                            S_OUT} state_t;
  state_t state_r;
  logic   out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.start     = in_valid && in_ready;
    cmd.seg_load  = (state_r == S_LOAD);
    cmd.seg_test  = (state_r == S_TEST);
    cmd.mul       = (state_r == S_MUL);
    cmd.div_start = (state_r == S_DIV);
    cmd.finish    = (state_r == S_FIN);
  end

  // input waits while a transaction is in flight or its result is pending
  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // hold the result until the receiver takes it
      out_valid_r <= (state_r == S_OUT) || (out_valid_r && !out_ready);
      unique case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          if (in_cmd == CMD_STEP) state_r <= cal_mode ? S_FIN : S_LOAD;
          else state_r <= S_OUT;
        end
        S_LOAD: state_r <= S_TEST;
        S_TEST: state_r <= S_CHK;
        // hit goes to multiply, miss advances or gives up after the last segment
        S_CHK: begin
          if (stat.seg_hit) state_r <= S_MUL;
          else if (stat.seg_last) state_r <= S_FIN;
          else state_r <= S_LOAD;
        end
        S_MUL:  state_r <= S_DIV;
        S_DIV:  state_r <= S_WAIT;
        S_WAIT: if (!stat.div_busy) state_r <= S_FIN;
        S_FIN:  state_r <= S_OUT;
        S_OUT:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sim/motor_speed_feedforward_with_selfcal_tb.sv @@
// Self-checking testbench for the speed feedforward block with self-calibration
`timescale 1ns / 1ps
module motor_speed_feedforward_with_selfcal_tb;
  import msff_pkg::*;

  localparam int NPTS = 11;
  localparam int WATCHDOG = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  msff_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  msff_out_t out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  motor_speed_feedforward_with_selfcal u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  // predictor state
  int unsigned m_rpm_max, m_pwm_max, m_knee, m_up, m_down, m_ki, m_dead, m_hold_steps;
  int unsigned m_ramp, m_stable, m_last, m_cal, m_point, m_hold;
  longint m_integ;
  int unsigned m_spd [NPTS];
  int unsigned m_drv [NPTS];
  int unsigned m_tol [NPTS];

  msff_in_t  pending_items [$];
  msff_out_t expected_results [$];
  int        send_idle_pct, recv_idle_pct;
  int        errors, results_seen, cal_saves, cal_dones, idle_cycles;
  bit        sending;

  function automatic int unsigned advance_ramp(int unsigned req);
    int unsigned t, s;
    t = (req > m_rpm_max) ? m_rpm_max : req;
    if (t > m_ramp) begin
      s = (m_ramp < m_knee) ? 1 : m_up;
      m_ramp = (t - m_ramp > s) ? m_ramp + s : t;
      m_stable = 0;
    end else if (t < m_ramp) begin
      s = (m_ramp < m_knee) ? 1 : m_down;
      m_ramp = (m_ramp - t > s) ? m_ramp - s : t;
      m_stable = 0;
    end else begin
      m_stable = 1;
    end
    return m_ramp;
  endfunction

  function automatic int unsigned table_lookup(int unsigned t);
    longint s0, s1, d0, dd, num;
    for (int i = 1; i < NPTS; i++) begin
      s0 = m_spd[i-1]; s1 = m_spd[i];
      if (t >= s0 && t <= s1) begin
        d0 = m_drv[i-1]; dd = longint'(m_drv[i]) - d0;
        if (s1 == s0) return 32'(d0);
        num = d0 * (s1 - s0) + dd * (longint'(t) - s0);
        if (num < 0) num = 0;
        return 32'(num / (s1 - s0));
      end
    end
    return 0;
  endfunction

  function automatic int unsigned integrate_drive(int unsigned tgt, int unsigned meas);
    longint err, mag, acc;
    err = longint'(tgt) - longint'(meas);
    mag = (err < 0) ? -err : err;
    acc = m_integ;
    if (mag > m_dead) acc += longint'(m_ki) * err;
    if (acc < 0) acc = 0;
    if (acc > longint'(m_pwm_max) * 65536) acc = longint'(m_pwm_max) * 65536;
    m_integ = acc;
    return 32'(m_integ >> 16);
  endfunction

  function automatic void model_reset();
    m_rpm_max = 2130; m_pwm_max = 4000; m_knee = 186; m_up = 2; m_down = 4;
    m_ki = 328; m_dead = 3; m_hold_steps = 300;
    m_ramp = 0; m_stable = 0; m_integ = 0; m_last = 0; m_cal = 0; m_point = NPTS - 1;
    m_hold = 0;
    for (int i = 0; i < NPTS; i++) begin
      m_spd[i] = def_speed(i); m_drv[i] = def_drive(i); m_tol[i] = def_tol(i);
    end
  endfunction

  function automatic void model_write_reg(logic [2:0] idx, logic [15:0] v);
    case (idx)
      REG_RPM_MAX:   m_rpm_max = v[11:0];
      REG_PWM_MAX:   m_pwm_max = v[11:0];
      REG_KNEE:      m_knee = v[11:0];
      REG_STEP_UP:   m_up = v[3:0];
      REG_STEP_DOWN: m_down = v[3:0];
      REG_KI:        m_ki = v;
      REG_DEADBAND:  m_dead = v[7:0];
      REG_HOLD:      m_hold_steps = v[11:0];
      default: ;
    endcase
  endfunction

  function automatic msff_out_t predict_drive(msff_in_t it);
    msff_out_t r;
    int unsigned drive, want, tgt, diff, p;
    r = '0;
    if (it.cmd == CMD_STEP) begin
      if (m_cal != 0) begin
        p = m_point;
        want = m_spd[p];
        tgt = advance_ramp(want);
        diff = (it.measured_rpm > want) ? it.measured_rpm - want : want - it.measured_rpm;
        if (diff <= m_tol[p]) begin
          if (m_hold >= m_hold_steps) begin
            m_hold = 0;
            m_drv[p] = m_last;
            r.point_saved = 1'b1; r.saved_index = 4'(p); r.saved_pwm = 12'(m_last);
            if (p > 1) begin
              m_point = p - 1;
            end else begin
              m_cal = 0; m_point = NPTS - 1; r.calibration_done = 1'b1;
            end
          end
        end else begin
          m_hold = 0;
        end
        drive = integrate_drive(tgt, it.measured_rpm);
      end else begin
        drive = table_lookup(advance_ramp(it.target_rpm));
      end
      if (drive > m_pwm_max) drive = m_pwm_max;
      m_last = drive;
      if (m_hold < m_hold_steps) m_hold++;
    end else if (it.cmd == CMD_LOAD) begin
      if (it.entry_index < NPTS) begin
        m_spd[it.entry_index] = it.entry_rpm;
        m_drv[it.entry_index] = it.entry_pwm;
      end
    end else if (it.cmd == CMD_START) begin
      m_cal = 1; m_point = NPTS - 1; m_hold = 0;
    end
    r.pwm_out = 12'(m_last); r.ramped_target = 12'(m_ramp);
    r.target_stable = m_stable[0]; r.calibrating = m_cal[0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_drive(in_data));
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    msff_out_t e;
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: %p", out_data);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (e.point_saved) cal_saves++;
          if (e.calibration_done) cal_dones++;
          if (out_data.pwm_out !== e.pwm_out) begin
            $error("pwm_out exp %0d got %0d", e.pwm_out, out_data.pwm_out); errors++;
          end
          if (out_data.ramped_target !== e.ramped_target) begin
            $error("ramped_target exp %0d got %0d", e.ramped_target, out_data.ramped_target);
            errors++;
          end
          if (out_data.target_stable !== e.target_stable) begin
            $error("target_stable exp %0d got %0d", e.target_stable, out_data.target_stable);
            errors++;
          end
          if (out_data.calibrating !== e.calibrating) begin
            $error("calibrating exp %0d got %0d", e.calibrating, out_data.calibrating);
            errors++;
          end
          if (out_data.point_saved !== e.point_saved) begin
            $error("point_saved exp %0d got %0d", e.point_saved, out_data.point_saved);
            errors++;
          end
          if (out_data.saved_index !== e.saved_index) begin
            $error("saved_index exp %0d got %0d", e.saved_index, out_data.saved_index);
            errors++;
          end
          if (out_data.saved_pwm !== e.saved_pwm) begin
            $error("saved_pwm exp %0d got %0d", e.saved_pwm, out_data.saved_pwm); errors++;
          end
          if (out_data.calibration_done !== e.calibration_done) begin
            $error("calibration_done exp %0d got %0d", e.calibration_done,
                   out_data.calibration_done);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("motor_speed_feedforward_with_selfcal regression: fail");
        $finish;
      end
    end
  end

  // drop valid on its own edge so back-to-back writes never collide
  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_write_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic msff_in_t make_item(logic [1:0] c, int unsigned tgt, int unsigned meas,
                                         int unsigned idx, int unsigned er, int unsigned ep);
    msff_in_t it;
    it.cmd = c; it.target_rpm = 12'(tgt); it.measured_rpm = 12'(meas);
    it.entry_index = 4'(idx); it.entry_rpm = 12'(er); it.entry_pwm = 12'(ep);
    return it;
  endfunction

  // random bits in unused fields keep every input bit toggling
  function automatic msff_in_t step_item(int unsigned tgt, int unsigned meas);
    return make_item(CMD_STEP, tgt, meas, $urandom_range(15), $urandom_range(4095),
                     $urandom_range(4095));
  endfunction

  // monotone table, sometimes with flat segments, or a random one when wild
  task automatic queue_table_load(bit wild);
    int unsigned s, d;
    s = 0; d = 0;
    for (int i = 0; i < NPTS; i++) begin
      if (wild) begin
        s = $urandom_range(4095); d = $urandom_range(4095);
      end else if (i > 0) begin
        s = ($urandom_range(3) == 0) ? s : ((s + $urandom_range(400) > 4095) ? 4095 :
            s + $urandom_range(400));
        d = (d + $urandom_range(400) > 4095) ? 4095 : d + $urandom_range(400);
      end
      pending_items.push_back(make_item(CMD_LOAD, $urandom_range(4095), $urandom_range(4095),
                                        i, s, d));
    end
  endtask

  // calibration: start, then steps whose measured speed mostly sits near a table point
  task automatic queue_calibration(int n);
    pending_items.push_back(make_item(CMD_START, $urandom_range(4095), $urandom_range(4095),
                                      $urandom_range(15), $urandom_range(4095),
                                      $urandom_range(4095)));
    for (int k = 0; k < n; k++) begin
      int unsigned p, w, m;
      p = 1 + (10 - (k / 12) % 10);
      if (p > 10) p = 10;
      w = m_spd[p];
      if ($urandom_range(9) == 0) m = $urandom_range(4095);
      else m = (w + $urandom_range(40) < 20) ? 0 : w + $urandom_range(40) - 20;
      if (m > 4095) m = 4095;
      pending_items.push_back(step_item($urandom_range(4095), m));
    end
  endtask

  task automatic run_random(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        pending_items.push_back(make_item(2'($urandom_range(3)), $urandom_range(4095),
                                          $urandom_range(4095), $urandom_range(15),
                                          $urandom_range(4095), $urandom_range(4095)));
      end else if (r < 5) begin
        queue_table_load($urandom_range(4) == 0);
        k += NPTS;
      end else begin
        pending_items.push_back(step_item(($urandom_range(3) == 0) ? $urandom_range(4095) :
                                          $urandom_range(2200), $urandom_range(4095)));
      end
    end
  endtask

  initial begin
    model_reset();
    send_idle_pct = 9; recv_idle_pct = 62;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every command, unused command, out-of-range load
    pending_items.push_back(step_item(0, 0));
    pending_items.push_back(step_item(4095, 4095));
    pending_items.push_back(step_item(4095, 0));
    pending_items.push_back(make_item(2'd3, 4095, 4095, 15, 4095, 4095));
    pending_items.push_back(make_item(CMD_LOAD, 0, 0, 15, 4095, 4095));
    pending_items.push_back(make_item(CMD_LOAD, 0, 0, 11, 123, 456));
    pending_items.push_back(make_item(CMD_LOAD, 0, 0, 3, 200, 4095));
    pending_items.push_back(make_item(CMD_LOAD, 0, 0, 4, 200, 0));
    pending_items.push_back(step_item(200, 0));
    pending_items.push_back(make_item(CMD_LOAD, 0, 0, 10, 0, 0));
    pending_items.push_back(step_item(4095, 0));
    pending_items.push_back(make_item(CMD_START, 0, 0, 0, 0, 0));
    pending_items.push_back(step_item(0, 4095));
    pending_items.push_back(step_item(0, 0));
    pending_items.push_back(make_item(CMD_START, 4095, 4095, 15, 4095, 4095));
    drain();

    // short hold, fast ramp, full gain
    write_reg(REG_HOLD, 16'd2); write_reg(REG_KI, 16'hffff); write_reg(REG_DEADBAND, 16'd0);
    write_reg(REG_STEP_UP, 16'd15); write_reg(REG_STEP_DOWN, 16'd15);
    write_reg(REG_KNEE, 16'd0); write_reg(REG_RPM_MAX, 16'd4095);
    write_reg(REG_PWM_MAX, 16'd4095);
    queue_calibration(150);
    run_random(400);
    drain();

    send_idle_pct = 62; recv_idle_pct = 9;
    write_reg(REG_HOLD, 16'd1); write_reg(REG_KI, 16'd0); write_reg(REG_DEADBAND, 16'd255);
    write_reg(REG_STEP_UP, 16'd1); write_reg(REG_STEP_DOWN, 16'd1);
    write_reg(REG_KNEE, 16'd4095); write_reg(REG_RPM_MAX, 16'd0);
    write_reg(REG_PWM_MAX, 16'd0);
    run_random(100);
    drain();
    write_reg(REG_RPM_MAX, 16'd2500); write_reg(REG_PWM_MAX, 16'd3000);
    write_reg(REG_KNEE, 16'd100); write_reg(REG_STEP_UP, 16'd8);
    write_reg(REG_STEP_DOWN, 16'd5); write_reg(REG_KI, 16'd5000);
    write_reg(REG_DEADBAND, 16'd6); write_reg(REG_HOLD, 16'd4);
    queue_calibration(150);
    run_random(350);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_HOLD, 16'd4095); write_reg(REG_KI, 16'd328);
    write_reg(REG_DEADBAND, 16'd3);
    queue_calibration(60);
    drain();
    write_reg(REG_HOLD, 16'd3);
    queue_calibration(150);
    run_random(550);
    drain();

    $display("covered %0d results, %0d calibrated points saved, %0d calibrations finished",
             results_seen, cal_saves, cal_dones);
    if (errors == 0) begin
      $display("motor_speed_feedforward_with_selfcal regression: pass");
    end else begin
      $display("motor_speed_feedforward_with_selfcal regression: fail");
    end
    $finish;
  end
endmodule
